// ----- design/dit_pkg.sv -----
// ----------------------------------------------------------------------------
// dit_pkg
// Shared types and constants of the disjoint interval tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package dit_pkg;

   localparam int MAX_RANGES_DEF = 32;
   localparam int VALUE_BITS_DEF = 16;
   localparam int RANGE_W        = 16;
   localparam int STATUS_W       = 3;

   typedef enum logic [STATUS_W-1:0] {
      ST_NEW     = 3'd0,
      ST_BELOW   = 3'd1,
      ST_ABOVE   = 3'd2,
      ST_BRIDGE  = 3'd3,
      ST_PRESENT = 3'd4,
      ST_FULL    = 3'd5,
      ST_LISTED  = 3'd6,
      ST_EMPTY   = 3'd7
   } status_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_LIST = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMMIT,
      S_LIST
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch value and compare flags of an add
      logic start_list;  // rewind the listing index
      logic commit;      // apply the add and load the result
      logic emit;        // load one listing result and rotate the table
   } dit_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic list_done;
   } dit_stat_type;

endpackage

`default_nettype wire

// ----- design/dit_datapath.sv -----
// ----------------------------------------------------------------------------
// dit_datapath
// Interval table cells, per-cell compare flags, update logic and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module dit_datapath
   import dit_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dit_cmd_type        cmd,
   output dit_stat_type            stat,
   input  wire logic [RANGE_W-1:0] req_value,
   output status_type              rsp_status,
   output logic [RANGE_W-1:0]      rsp_start,
   output logic [RANGE_W-1:0]      rsp_end,
   output logic                    rsp_last
);

   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   logic [VALUE_BITS-1:0] start_ff [MAX_RANGES];
   logic [VALUE_BITS-1:0] start_in [MAX_RANGES];
   logic [VALUE_BITS-1:0] end_ff   [MAX_RANGES];
   logic [VALUE_BITS-1:0] end_in   [MAX_RANGES];
   logic [VALUE_BITS-1:0] next_start [MAX_RANGES];
   logic [VALUE_BITS-1:0] next_end   [MAX_RANGES];
   logic [VALUE_BITS-1:0] prev_start [MAX_RANGES];
   logic [VALUE_BITS-1:0] prev_end   [MAX_RANGES];

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [VALUE_BITS-1:0] val_ff, val_in, req_val;
   logic [MAX_RANGES-1:0] le_ff, le_in;
   logic [MAX_RANGES-1:0] in_count, is_below, ins, last_cell;

   logic [VALUE_BITS-1:0] b_start, b_end, a_start, a_end;
   logic                  has_below, above_ok, present, join_below, join_above, full;
   status_type            outcome;

   status_type            status_ff, status_in;
   logic [RANGE_W-1:0]    rstart_ff, rstart_in, rend_ff, rend_in;
   logic                  last_ff, last_in;

   assign req_val = VALUE_BITS'(req_value);

   // per-cell flags and fixed neighbour taps
   for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
      assign in_count[i]  = (CNT_W'(i) < count_ff);
      assign last_cell[i] = (CNT_W'(i + 1) == count_ff);
      assign le_in[i]     = in_count[i] && (start_ff[i] <= req_val);

      if (i == MAX_RANGES - 1) begin : g_top
         assign next_start[i] = start_ff[i];
         assign next_end[i]   = end_ff[i];
         assign is_below[i]   = le_ff[i];
      end else begin : g_mid
         assign next_start[i] = start_ff[i + 1];
         assign next_end[i]   = end_ff[i + 1];
         assign is_below[i]   = le_ff[i] & ~le_ff[i + 1];
      end

      if (i == 0) begin : g_bot
         assign prev_start[i] = start_ff[i];
         assign prev_end[i]   = end_ff[i];
         assign ins[i]        = ~le_ff[i];
      end else begin : g_low
         assign prev_start[i] = start_ff[i - 1];
         assign prev_end[i]   = end_ff[i - 1];
         assign ins[i]        = ~le_ff[i] & le_ff[i - 1];
      end

      always_comb begin
         start_in[i] = start_ff[i];
         end_in[i]   = end_ff[i];
         if (cmd.commit) begin
            case (outcome)
               ST_BRIDGE: begin
                  if (is_below[i]) begin
                     end_in[i] = next_end[i];
                  end else if (!le_ff[i]) begin
                     start_in[i] = next_start[i];
                     end_in[i]   = next_end[i];
                  end
               end
               ST_BELOW: begin
                  if (is_below[i]) end_in[i] = val_ff;
               end
               ST_ABOVE: begin
                  if (ins[i]) start_in[i] = val_ff;
               end
               ST_NEW: begin
                  if (ins[i]) begin
                     start_in[i] = val_ff;
                     end_in[i]   = val_ff;
                  end else if (!le_ff[i]) begin
                     start_in[i] = prev_start[i];
                     end_in[i]   = prev_end[i];
                  end
               end
               default: begin
               end
            endcase
         end else if (cmd.emit) begin
            // rotate the stored intervals by one so cell 0 holds the next one
            if (last_cell[i]) begin
               start_in[i] = start_ff[0];
               end_in[i]   = end_ff[0];
            end else if (in_count[i]) begin
               start_in[i] = next_start[i];
               end_in[i]   = next_end[i];
            end
         end
      end
   end

   // pick the neighbours of the value from the one-hot position flags
   always_comb begin
      b_start = '0;
      b_end   = '0;
      a_start = '0;
      a_end   = '0;
      for (int k = 0; k < MAX_RANGES; k++) begin
         b_start = b_start | (is_below[k] ? start_ff[k] : '0);
         b_end   = b_end   | (is_below[k] ? end_ff[k]   : '0);
         a_start = a_start | (ins[k] ? start_ff[k] : '0);
         a_end   = a_end   | (ins[k] ? end_ff[k]   : '0);
      end
   end

   always_comb begin
      has_below  = le_ff[0];
      above_ok   = |(ins & in_count);
      present    = has_below && (b_end >= val_ff);
      join_below = has_below && (({1'b0, b_end} + 1'b1) == {1'b0, val_ff});
      join_above = above_ok && (val_ff != '1) &&
                   ({1'b0, a_start} == ({1'b0, val_ff} + 1'b1));
      full       = (count_ff == CNT_W'(MAX_RANGES));
      if (present)                      outcome = ST_PRESENT;
      else if (join_below && join_above) outcome = ST_BRIDGE;
      else if (join_below)              outcome = ST_BELOW;
      else if (join_above)              outcome = ST_ABOVE;
      else if (full)                    outcome = ST_FULL;
      else                              outcome = ST_NEW;
   end

   always_comb begin
      val_in   = cmd.capture ? req_val : val_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (cmd.start_list) idx_in = '0;
      else if (cmd.emit)  idx_in = idx_ff + 1'b1;
      if (cmd.commit && outcome == ST_BRIDGE) count_in = count_ff - 1'b1;
      else if (cmd.commit && outcome == ST_NEW) count_in = count_ff + 1'b1;
   end

   assign stat.list_done = (count_ff == '0) || (CNT_W'(idx_ff + 1'b1) == count_ff);

   always_comb begin
      status_in = status_ff;
      rstart_in = rstart_ff;
      rend_in   = rend_ff;
      last_in   = last_ff;
      if (cmd.commit) begin
         status_in = outcome;
         last_in   = 1'b1;
         case (outcome)
            ST_PRESENT: begin
               rstart_in = RANGE_W'(b_start);
               rend_in   = RANGE_W'(b_end);
            end
            ST_BRIDGE: begin
               rstart_in = RANGE_W'(b_start);
               rend_in   = RANGE_W'(a_end);
            end
            ST_BELOW: begin
               rstart_in = RANGE_W'(b_start);
               rend_in   = RANGE_W'(val_ff);
            end
            ST_ABOVE: begin
               rstart_in = RANGE_W'(val_ff);
               rend_in   = RANGE_W'(a_end);
            end
            default: begin
               rstart_in = RANGE_W'(val_ff);
               rend_in   = RANGE_W'(val_ff);
            end
         endcase
      end else if (cmd.emit) begin
         last_in = stat.list_done;
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
            rstart_in = '0;
            rend_in   = '0;
         end else begin
            status_in = ST_LISTED;
            rstart_in = RANGE_W'(start_ff[0]);
            rend_in   = RANGE_W'(end_ff[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RANGES; k++) begin
         start_ff[k] <= start_in[k];
         end_ff[k]   <= end_in[k];
      end
      val_ff    <= val_in;
      if (cmd.capture) le_ff <= le_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rstart_ff <= rstart_in;
      rend_ff   <= rend_in;
      last_ff   <= last_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_start  = rstart_ff;
   assign rsp_end    = rend_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

// ----- design/dit_ctrl.sv -----
// ----------------------------------------------------------------------------
// dit_ctrl
// Sequencer of the tracker: input handshake, add commit, listing, result
// valid.
// ----------------------------------------------------------------------------
`default_nettype none

module dit_ctrl
   import dit_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic         req_op,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output dit_cmd_type       cmd,
   input  wire dit_stat_type stat
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = (req_op == OP_LIST) ? S_LIST : S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         S_LIST: begin
            if (out_free && stat.list_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == S_IDLE);
      cmd.capture    = (state_ff == S_IDLE) && req_tvalid && (req_op == OP_ADD);
      cmd.start_list = (state_ff == S_IDLE) && req_tvalid && (req_op == OP_LIST);
      cmd.commit     = (state_ff == S_COMMIT) && out_free;
      cmd.emit       = (state_ff == S_LIST) && out_free;
      // hold the result until taken, reload when a new one is produced
      if (cmd.commit || cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready)         rsp_valid_in = 1'b0;
      else                         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/disjoint_interval_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// disjoint_interval_tracker_unit
// Sorted set of disjoint inclusive intervals with add and list transactions.
// ----------------------------------------------------------------------------
// Input channel req_*: tuser carries the operation (add or list), tdata the
// value to add. Result channel rsp_*: tuser carries the status code, tdata
// the interval bounds, tlast marks the final result of a transaction.
// An add gives one result. On acceptance the value is compared against
// every stored interval in parallel and the flags are registered; the
// commit state then applies it (shift, merge or bridge of the cells) and
// loads the result register, waiting while that register is still full.
// A list with N stored intervals gives N results, one per cycle while the
// receiver takes them, by rotating the table through cell 0 (one result if empty).
// The result register lets the next transaction be accepted while a result
// waits; if the receiver stalls, the commit or listing step waits for the
// result register to free up, and the input channel stays closed meanwhile.
// Reset empties the table and clears the result channel; no sweep needed.
// ----------------------------------------------------------------------------
`default_nettype none

module disjoint_interval_tracker_unit
   import dit_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] value
   input  wire logic        req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] range_start, [31:16] range_end
   output logic [2:0]       rsp_tuser,   // [2:0] status
   output logic             rsp_tlast
);

   dit_cmd_type        cmd;
   dit_stat_type       stat;
   status_type         status;
   logic [RANGE_W-1:0] range_start, range_end;

   dit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dit_datapath #(
      .MAX_RANGES (MAX_RANGES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_value  (req_tdata),
      .rsp_status (status),
      .rsp_start  (range_start),
      .rsp_end    (range_end),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {range_end, range_start};
   assign rsp_tuser = status;

endmodule

`default_nettype wire
